FILE: rtl/core/tree_address_route_resolver_unit_assert.svh
// Assertion macros used by the route resolver checker.
`ifndef TREE_ADDRESS_ROUTE_RESOLVER_UNIT_ASSERT_SVH
`define TREE_ADDRESS_ROUTE_RESOLVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TARR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TARR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tarr_pkg.sv
// Shared widths, codes and address translation functions of the route resolver.
`default_nettype none

package tarr_pkg;

  // Field widths.
  localparam int DEST_W  = 16;
  localparam int MODE_W  = 3;
  localparam int NODE_W  = 12;
  localparam int PIPE_W  = 3;
  localparam int RADIO_W = 40;
  localparam int DIGIT_W = 3;

  // Octal digit counts of the destination and own address, and radio address bytes.
  localparam int DEST_DIGITS = (DEST_W + DIGIT_W - 1) / DIGIT_W;
  localparam int OWN_DIGITS  = NODE_W / DIGIT_W;
  localparam int RADIO_BYTES = RADIO_W / 8;

  // Destinations that are always accepted although they contain zero digits.
  localparam logic [DEST_W-1:0] ADDR_SPECIAL_HI = 16'o100;
  localparam logic [DEST_W-1:0] ADDR_SPECIAL_LO = 16'o10;

  // Child slots on one level run from one to five.
  localparam logic [DIGIT_W-1:0] SLOT_MIN = 3'd1;
  localparam logic [DIGIT_W-1:0] SLOT_MAX = 3'd5;

  // Modes above the routed mode send straight to the physical node.
  localparam logic [MODE_W-1:0] MODE_ROUTED = 3'd1;

  // Pipe numbers used on the next hop.
  localparam logic [PIPE_W-1:0] PIPE_DIRECT = 3'd0;
  localparam logic [PIPE_W-1:0] PIPE_CHILD  = 3'd5;

  // Filler byte of the radio address.
  localparam logic [7:0] BYTE_DEFAULT = 8'hCC;

  // One result transaction.
  typedef struct packed {
    logic               dest_valid;
    logic [NODE_W-1:0]  next_node;
    logic [PIPE_W-1:0]  next_pipe;
    logic               multicast;
    logic [RADIO_W-1:0] radio_address;
  } route_result_t;

  // Byte translation of one octal value; seven has no entry and keeps the filler.
  function automatic logic [7:0] xlate_byte(input logic [DIGIT_W-1:0] val);
    logic [7:0] b;
    case (val)
      3'd0:    b = 8'hc3;
      3'd1:    b = 8'h3c;
      3'd2:    b = 8'h33;
      3'd3:    b = 8'hce;
      3'd4:    b = 8'h3e;
      3'd5:    b = 8'he3;
      3'd6:    b = 8'hec;
      default: b = BYTE_DEFAULT;
    endcase
    return b;
  endfunction

  // Radio address: pipe byte at the bottom, then one byte per octal digit of the node.
  function automatic logic [RADIO_W-1:0] radio_addr(input logic [DEST_W-1:0] node,
                                                    input logic [PIPE_W-1:0] pipe);
    logic [RADIO_W-1:0] r;
    r[7:0] = xlate_byte(pipe);
    for (int k = 0; k < RADIO_BYTES - 1; k++) begin
      if ((node >> (DIGIT_W * k)) != '0) begin
        r[8*(k+1) +: 8] = xlate_byte(node[DIGIT_W*k +: DIGIT_W]);
      end else begin
        r[8*(k+1) +: 8] = BYTE_DEFAULT;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tarr_if.sv
// Valid/ready channel interfaces for the route resolver input and result.
`default_nettype none

interface tarr_in_if import tarr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_node;
  logic [MODE_W-1:0] mode;

  modport source(output valid, output dest_node, output mode, input ready);
  modport sink(input valid, input dest_node, input mode, output ready);
endinterface

interface tarr_out_if import tarr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               dest_valid;
  logic [NODE_W-1:0]  next_node;
  logic [PIPE_W-1:0]  next_pipe;
  logic               multicast;
  logic [RADIO_W-1:0] radio_address;

  modport source(output valid, output dest_valid, output next_node, output next_pipe,
                 output multicast, output radio_address, input ready);
  modport sink(input valid, input dest_valid, input next_node, input next_pipe,
               input multicast, input radio_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tree_address_route_resolver_unit.sv
// Top level of the octal tree route resolver: input register, route logic, result register.
// A transaction accepted on the input channel passes the input register and then the result
// register, from which it is offered on the result channel. Throughput: one transaction per
// cycle while the result channel is ready; each register advances when it is empty or its
// transaction moves on. Reset: rst_n is synchronous and active low; it empties both registers
// and sets own address, level mask, parent node and parent pipe to zero (the master).
`default_nettype none

module tree_address_route_resolver_unit import tarr_pkg::*; #(
  parameter int MAX_LEVELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [NODE_W-1:0] cfg_wr_data,
  tarr_in_if.sink           in_ch,
  tarr_out_if.source        out_ch
);

  // Configuration and values derived from it.
  logic [NODE_W-1:0] own_r,         own_nxt;
  logic [NODE_W-1:0] mask_r,        mask_nxt;
  logic [NODE_W-1:0] parent_node_r, parent_node_nxt;
  logic [PIPE_W-1:0] parent_pipe_r, parent_pipe_nxt;
  logic [OWN_DIGITS-1:0] own_nz;

  // Pipeline registers.
  logic              s1_valid_r;
  logic [DEST_W-1:0] s1_dest_r;
  logic [MODE_W-1:0] s1_mode_r;
  logic              out_valid_r;
  route_result_t     out_item_r, out_item_nxt;
  logic              out_adv;
  logic              s1_adv;

  // Route logic signals.
  logic [DEST_W-1:0]              own16;
  logic [DEST_W-1:0]              mask16;
  logic [DEST_W-1:0]              deeper;
  logic [DEST_W-1:0]              desc_mask;
  logic [DIGIT_W*DEST_DIGITS-1:0] dest_ext;
  logic [DIGIT_W-1:0]             digit;
  logic                           digits_ok;
  logic                           len_ok;
  logic                           addr_ok;
  logic                           in_subtree;
  logic                           direct;
  logic [DEST_W-1:0]              hop_node;
  logic [PIPE_W-1:0]              hop_pipe;

  // Level mask, parent node and parent pipe follow from the digits of the written address.
  always_comb begin
    own_nxt         = cfg_wr_data;
    mask_nxt        = '0;
    parent_node_nxt = '0;
    parent_pipe_nxt = PIPE_DIRECT;
    for (int k = 0; k < OWN_DIGITS; k++) begin
      own_nz[k] = (cfg_wr_data >> (DIGIT_W * k)) != '0;
    end
    for (int k = 0; k < OWN_DIGITS; k++) begin
      mask_nxt[DIGIT_W*k +: DIGIT_W] = {DIGIT_W{own_nz[k]}};
      if (own_nz[k]) begin
        parent_pipe_nxt = cfg_wr_data[DIGIT_W*k +: DIGIT_W];
      end
    end
    for (int k = 0; k < OWN_DIGITS - 1; k++) begin
      if (own_nz[k+1]) begin
        parent_node_nxt[DIGIT_W*k +: DIGIT_W] = cfg_wr_data[DIGIT_W*k +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r         <= '0;
      mask_r        <= '0;
      parent_node_r <= '0;
      parent_pipe_r <= PIPE_DIRECT;
    end else if (cfg_wr_en) begin
      own_r         <= own_nxt;
      mask_r        <= mask_nxt;
      parent_node_r <= parent_node_nxt;
      parent_pipe_r <= parent_pipe_nxt;
    end
  end

  // Destination check: special address, or slot digits up to top nonzero one, length bounded.
  always_comb begin
    dest_ext  = {{(DIGIT_W*DEST_DIGITS-DEST_W){1'b0}}, s1_dest_r};
    digits_ok = 1'b1;
    digit     = '0;
    for (int k = 0; k < DEST_DIGITS; k++) begin
      digit = dest_ext[DIGIT_W*k +: DIGIT_W];
      if (((s1_dest_r >> (DIGIT_W * k)) != '0) && ((digit < SLOT_MIN) || (digit > SLOT_MAX)))
      begin
        digits_ok = 1'b0;
      end
    end
    len_ok  = (s1_dest_r >> (DIGIT_W * MAX_LEVELS)) == '0;
    addr_ok = (s1_dest_r == ADDR_SPECIAL_HI) || (s1_dest_r == ADDR_SPECIAL_LO) ||
              (digits_ok && len_ok);
  end

  // Next hop: direct send, own subtree through pipe five, or up to the parent.
  always_comb begin
    own16      = {{(DEST_W-NODE_W){1'b0}}, own_r};
    mask16     = {{(DEST_W-NODE_W){1'b0}}, mask_r};
    deeper     = {~mask16[DEST_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    desc_mask  = {mask16[DEST_W-DIGIT_W-1:0], {DIGIT_W{1'b1}}};
    in_subtree = (s1_dest_r & mask16) == own16;
    direct     = s1_mode_r > MODE_ROUTED;
    if (direct) begin
      hop_node = s1_dest_r;
      hop_pipe = PIPE_DIRECT;
    end else if (in_subtree) begin
      hop_node = ((s1_dest_r & deeper) == '0) ? s1_dest_r : (s1_dest_r & desc_mask);
      hop_pipe = PIPE_CHILD;
    end else begin
      hop_node = {{(DEST_W-NODE_W){1'b0}}, parent_node_r};
      hop_pipe = parent_pipe_r;
    end
  end

  // Result transaction; an invalid destination gives all zero fields.
  always_comb begin
    out_item_nxt = '0;
    if (addr_ok) begin
      out_item_nxt.dest_valid    = 1'b1;
      out_item_nxt.next_node     = hop_node[NODE_W-1:0];
      out_item_nxt.next_pipe     = hop_pipe;
      out_item_nxt.multicast     = direct;
      out_item_nxt.radio_address = radio_addr(hop_node, hop_pipe);
    end
  end

  // Both registers move whenever the result register is empty or being taken.
  assign out_adv     = !out_valid_r || out_ch.ready;
  assign s1_adv      = !s1_valid_r || out_adv;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Payload registers load only with a transaction.
  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_dest_r <= in_ch.dest_node;
      s1_mode_r <= in_ch.mode;
    end
    if (out_adv && s1_valid_r) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Result channel.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.dest_valid    = out_item_r.dest_valid;
  assign out_ch.next_node     = out_item_r.next_node;
  assign out_ch.next_pipe     = out_item_r.next_pipe;
  assign out_ch.multicast     = out_item_r.multicast;
  assign out_ch.radio_address = out_item_r.radio_address;

endmodule

`default_nettype wire

FILE: rtl/core/tarr_checker.sv
// Port-level checker of the route resolver and its bind to the top level.
`default_nettype none
`include "tree_address_route_resolver_unit_assert.svh"

module tarr_checker import tarr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               dest_valid,
  input logic [NODE_W-1:0]  next_node,
  input logic [PIPE_W-1:0]  next_pipe,
  input logic               multicast,
  input logic [RADIO_W-1:0] radio_address
);

  // A rejected destination carries no routing information.
  `TARR_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_valid && !dest_valid, next_node == '0 && next_pipe == '0 && !multicast && radio_address == '0, "invalid destination with nonzero fields")

  // A direct send always uses the direct pipe and its address byte.
  `TARR_ASSERT_NOW(a_multicast_pipe, clk, rst_n, out_valid && multicast, dest_valid && next_pipe == PIPE_DIRECT && radio_address[7:0] == xlate_byte(PIPE_DIRECT), "direct send on wrong pipe")

  // For a valid destination the low radio address byte names the chosen pipe.
  `TARR_ASSERT_NOW(a_pipe_byte, clk, rst_n, out_valid && dest_valid, radio_address[7:0] == xlate_byte(next_pipe), "radio address pipe byte mismatch")

  // A stalled result transaction holds its payload.
  `TARR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(dest_valid) && $stable(next_node) && $stable(next_pipe) && $stable(multicast) && $stable(radio_address), "stalled result changed")

endmodule

bind tree_address_route_resolver_unit tarr_checker u_tarr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .dest_valid    (out_ch.dest_valid),
  .next_node     (out_ch.next_node),
  .next_pipe     (out_ch.next_pipe),
  .multicast     (out_ch.multicast),
  .radio_address (out_ch.radio_address)
);

`default_nettype wire
